[design/averaging_sweep_recorder_assert.svh]
// Assertion macros for the averaging sweep recorder checker.
// No dependencies; included by the checker file.
`ifndef AVERAGING_SWEEP_RECORDER_ASSERT_SVH
`define AVERAGING_SWEEP_RECORDER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ASR_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("asr check failed");

// next-cycle implication, disabled while reset is low
`define ASR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("asr check failed");

`endif

[design/asr_pkg.sv]
// Shared constants, codes and structs for the averaging sweep recorder.
// No dependencies; used by every other design file except the assertion macro header.
package asr_pkg;

  // buffer geometry
  localparam int MAX_SIGNALS = 8;
  localparam int MAX_POINTS  = 2048;

  // item field widths
  localparam int KIND_W   = 3;
  localparam int SAMPLE_W = 32;
  localparam int SIG_W    = 3;
  localparam int PT_W     = 11;
  localparam int CNT_W    = 12;
  localparam int AVG_W    = 16;

  // arithmetic widths
  localparam int SUM_W = 48;
  localparam int NUM_W = SUM_W + 2;   // 2*sum + n, signed
  localparam int DIV_W = NUM_W - 1;   // magnitude of the numerator
  localparam int DVS_W = AVG_W + 1;   // 2*n
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // sweep buffer address {signal, point}
  localparam int ADDR_W    = SIG_W + PT_W;
  localparam int BUF_DEPTH = MAX_SIGNALS * MAX_POINTS;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_AVERAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 1'b1;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 3'd0,
    KIND_START  = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // buffer ports
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

[design/asr_ifs.sv]
// Valid/ready channel interfaces for the recorder's input and result items.
// Depends on asr_pkg for the field widths.
interface asr_in_if import asr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [SIG_W-1:0]           signal_index;
  logic                       last_signal;
  logic [PT_W-1:0]            read_point;

  modport source (output valid, kind, sample_value, signal_index, last_signal, read_point,
                  input ready);
  modport sink   (input valid, kind, sample_value, signal_index, last_signal, read_point,
                  output ready);
endinterface

interface asr_out_if import asr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] read_data;
  logic [CNT_W-1:0]           points_acquired;
  logic                       acquiring;
  logic                       point_done;

  modport source (output valid, read_data, points_acquired, acquiring, point_done,
                  input ready);
  modport sink   (input valid, read_data, points_acquired, acquiring, point_done,
                  output ready);
endinterface

[design/asr_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on asr_pkg for widths and the request/response structs.
module asr_div import asr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  d_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  // one trial subtraction per step
  always_comb begin
    trial = {rem_r, q_r[DIV_W-1]};
    diff  = trial - {1'b0, d_r};
    fits  = (trial >= {1'b0, d_r});
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      d_r   <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

[design/asr_buffer.sv]
// Sweep buffer: one write port, one read port with registered read data.
// Depends on asr_pkg for geometry and port structs.
module asr_buffer import asr_pkg::*; (
  input  logic                clk,
  input  mem_wr_t             wr,
  input  mem_rd_t             rd,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [BUF_DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/averaging_sweep_recorder.sv]
// Averaging sweep recorder: sequencer, running sums, status and result register.
// Depends on asr_pkg, asr_ifs (channels), asr_div and asr_buffer.
//
// Accepts one item at a time. Control items and samples that do not finish a
// point pass from accept through the execute state to the output register; a
// read also passes a wait state for the registered buffer read port. A sample
// that finishes a point writes all signals one after another: with an
// averaging count of 1 (or 0) that is one signal per cycle; otherwise each
// signal goes through a load and a prepare step and the shared serial divider
// (49 quotient bits, one per cycle) before its write-back. Erase is immediate:
// the buffer reads zero past the acquired point count, so no clearing pass is
// needed after reset or erase. The next item is taken while a finished result
// still waits in the output register.
module averaging_sweep_recorder import asr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  asr_in_if.sink                in_ch,
  asr_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_LOAD,
    S_PREP,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  // control state
  state_t           state_r, state_nxt;
  logic [SUM_W-1:0] sums_r [MAX_SIGNALS];
  logic [SUM_W-1:0] sums_nxt [MAX_SIGNALS];
  logic [AVG_W-1:0] gc_r, gc_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic             running_r, running_nxt;
  logic [AVG_W-1:0] na_r, na_nxt;
  logic [CNT_W-1:0] np_r, np_nxt;
  logic [SIG_W-1:0] s_r, s_nxt;
  logic             out_valid_r, out_valid_nxt;

  // item and result payload
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SIG_W-1:0]    sig_r, sig_nxt;
  logic                last_r, last_nxt;
  logic [PT_W-1:0]     pt_r, pt_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic                neg_r, neg_nxt;
  logic [SAMPLE_W-1:0] rd_r, rd_nxt;
  logic                done_r, done_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]    out_pc_r, out_pc_nxt;
  logic                out_run_r, out_run_nxt;
  logic                out_done_r, out_done_nxt;

  // shared units
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  mem_wr_t             mem_wr;
  mem_rd_t             mem_rd;
  logic [SAMPLE_W-1:0] mem_rdata;

  // helpers
  logic [AVG_W-1:0]    n_eff;
  logic [AVG_W-1:0]    gc_inc;
  logic [SIG_W-1:0]    sum_idx;
  logic [SUM_W-1:0]    sum_rd;
  logic                sig_ok;
  logic                rd_hit;
  logic                pc_room;
  logic [CNT_W-1:0]    pc_new;
  logic [NUM_W-1:0]    num_mag;
  logic [SAMPLE_W-1:0] q_lo;
  logic [CNT_W-1:0]    cfg_np;

  asr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  asr_buffer u_buf (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  // shared helper terms
  always_comb begin
    n_eff   = (na_r == '0) ? AVG_W'(1) : na_r;
    gc_inc  = gc_r + AVG_W'(1);
    sum_idx = (state_r == S_EXEC) ? sig_r : s_r;
    sum_rd  = sums_r[sum_idx];
    sig_ok  = ({1'b0, sig_r} < (SIG_W+1)'(MAX_SIGNALS));
    rd_hit  = sig_ok && ({1'b0, pt_r} < pc_r) && ({1'b0, pt_r} < (PT_W+1)'(MAX_POINTS));
    pc_room = (pc_r < CNT_W'(MAX_POINTS));
    pc_new  = pc_room ? (pc_r + CNT_W'(1)) : pc_r;
    num_mag = num_r[NUM_W-1] ? (~num_r + NUM_W'(1)) : num_r;
    q_lo    = neg_r ? (~div_rsp.quotient[SAMPLE_W-1:0] + SAMPLE_W'(1))
                    : div_rsp.quotient[SAMPLE_W-1:0];
    cfg_np  = cfg_data[CNT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sums_nxt      = sums_r;
    gc_nxt        = gc_r;
    pc_nxt        = pc_r;
    running_nxt   = running_r;
    na_nxt        = na_r;
    np_nxt        = np_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    sample_nxt    = sample_r;
    sig_nxt       = sig_r;
    last_nxt      = last_r;
    pt_nxt        = pt_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    rd_nxt        = rd_r;
    done_nxt      = done_r;
    out_data_nxt  = out_data_r;
    out_pc_nxt    = out_pc_r;
    out_run_nxt   = out_run_r;
    out_done_nxt  = out_done_r;
    div_req       = '0;
    mem_wr        = '0;
    mem_rd        = '0;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt   = in_ch.kind;
          sample_nxt = in_ch.sample_value;
          sig_nxt    = in_ch.signal_index;
          last_nxt   = in_ch.last_signal;
          pt_nxt     = in_ch.read_point;
          rd_nxt     = '0;
          done_nxt   = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        case (kind_r)
          KIND_SAMPLE: begin
            if (running_r) begin
              if (sig_ok) begin
                sums_nxt[sig_r] = sum_rd + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
              end
              if (last_r) begin
                gc_nxt = gc_inc;
                if (gc_inc >= n_eff) begin
                  s_nxt     = '0;
                  state_nxt = S_LOAD;
                end
              end
            end
          end
          KIND_START: running_nxt = 1'b1;
          KIND_STOP:  running_nxt = 1'b0;
          KIND_ERASE: pc_nxt = '0;
          KIND_READ: begin
            mem_rd.re   = 1'b1;
            mem_rd.addr = {sig_r, pt_r};
            state_nxt   = S_RDWAIT;
          end
          default: ;
        endcase
      end

      S_RDWAIT: begin
        rd_nxt    = rd_hit ? mem_rdata : '0;
        state_nxt = S_OUT;
      end

      // pick up one signal's sum and clear it
      S_LOAD: begin
        num_nxt         = {sum_rd[SUM_W-1], sum_rd, 1'b0} + NUM_W'(n_eff);
        sums_nxt[s_r]   = '0;
        if (n_eff == AVG_W'(1)) begin
          mem_wr.we   = pc_room;
          mem_wr.addr = {s_r, pc_r[PT_W-1:0]};
          mem_wr.data = sum_rd[SAMPLE_W-1:0];
          s_nxt       = s_r + SIG_W'(1);
          if (s_r == SIG_W'(MAX_SIGNALS - 1)) begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_PREP;
        end
      end

      // divide |2*sum + n| by 2*n
      S_PREP: begin
        neg_nxt          = num_r[NUM_W-1];
        div_req.start    = 1'b1;
        div_req.dividend = num_mag[DIV_W-1:0];
        div_req.divisor  = {n_eff, 1'b0};
        state_nxt        = S_DIV;
      end

      S_DIV: begin
        if (div_rsp.done) begin
          mem_wr.we   = pc_room;
          mem_wr.addr = {s_r, pc_r[PT_W-1:0]};
          mem_wr.data = q_lo;
          s_nxt       = s_r + SIG_W'(1);
          state_nxt   = (s_r == SIG_W'(MAX_SIGNALS - 1)) ? S_FIN : S_LOAD;
        end
      end

      // point complete
      S_FIN: begin
        gc_nxt   = '0;
        pc_nxt   = pc_new;
        done_nxt = 1'b1;
        if (pc_new >= np_r) begin
          running_nxt = 1'b0;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = rd_r;
          out_pc_nxt    = pc_r;
          out_run_nxt   = running_r;
          out_done_nxt  = done_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // register writes must arrive only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_AVERAGE: begin
          na_nxt = cfg_data[AVG_W-1:0];
          gc_nxt = '0;
        end
        CFG_NUM_POINTS: begin
          if ((cfg_np >= CNT_W'(1)) && (cfg_np <= CNT_W'(MAX_POINTS))) begin
            np_nxt = cfg_np;
          end
        end
        default: ;
      endcase
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < MAX_SIGNALS; i++) begin
        sums_r[i] <= '0;
      end
      gc_r        <= '0;
      pc_r        <= '0;
      running_r   <= 1'b0;
      na_r        <= AVG_W'(1);
      np_r        <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sums_r      <= sums_nxt;
      gc_r        <= gc_nxt;
      pc_r        <= pc_nxt;
      running_r   <= running_nxt;
      na_r        <= na_nxt;
      np_r        <= np_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    sample_r   <= sample_nxt;
    sig_r      <= sig_nxt;
    last_r     <= last_nxt;
    pt_r       <= pt_nxt;
    num_r      <= num_nxt;
    neg_r      <= neg_nxt;
    rd_r       <= rd_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
    out_pc_r   <= out_pc_nxt;
    out_run_r  <= out_run_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_data_r;
  assign out_ch.points_acquired = out_pc_r;
  assign out_ch.acquiring       = out_run_r;
  assign out_ch.point_done      = out_done_r;

endmodule

[design/asr_checker.sv]
// Port-level checks for the averaging sweep recorder, bound to the top level.
// Depends on asr_pkg and averaging_sweep_recorder_assert.svh.
`include "averaging_sweep_recorder_assert.svh"

module asr_checker import asr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_read_data,
  input logic [CNT_W-1:0]    out_points_acquired,
  input logic                out_acquiring,
  input logic                out_point_done
);

  // result valid and payload as one vector for the hold check
  logic [SAMPLE_W+CNT_W+2:0] out_bundle;
  assign out_bundle = {out_valid, out_read_data, out_points_acquired, out_acquiring,
                       out_point_done};

  // one item at a time: busy right after an accept
  `ASR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `ASR_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, $stable(out_bundle))

  // a finished point comes from a sample, which reads nothing
  `ASR_ASSERT_IMPLY(a_done_no_data, clk, rst_n, out_valid && out_point_done, out_read_data == '0)

  // point count stays within the buffer
  `ASR_ASSERT_IMPLY(a_count_bound, clk, rst_n, out_valid, out_points_acquired <= CNT_W'(MAX_POINTS))

endmodule

bind averaging_sweep_recorder asr_checker u_asr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_read_data       (out_ch.read_data),
  .out_points_acquired (out_ch.points_acquired),
  .out_acquiring       (out_ch.acquiring),
  .out_point_done      (out_ch.point_done)
);
